[hw/rtl/version_string_compare_core_defines.svh]
// Assertion macros shared by the version compare RTL
`ifndef VERSION_STRING_COMPARE_CORE_DEFINES_SVH
`define VERSION_STRING_COMPARE_CORE_DEFINES_SVH
// Implication checked on every clock, skipped while reset is high
`define VSC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsc check failed");
// Next-cycle implication
`define VSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsc check failed");
`endif

[hw/rtl/vsc_pkg.sv]
// Package: types, constants and commands of the version string compare core
`default_nettype none
package vsc_pkg;
  localparam int MaxTextDef  = 256;
  localparam int MaxPartsDef = 64;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeDigit = 2'd1;
  localparam logic [1:0] ModeAlpha = 2'd2;
  localparam logic [1:0] ModeEnded = 2'd3;
  localparam logic [1:0] OrdLess = 2'b11;
  localparam logic [1:0] OrdEq   = 2'b00;
  localparam logic [1:0] OrdMore = 2'b01;
  // byte address of the reverse_order register
  localparam logic [1:0] AddrReverse = 2'd0;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       string_sel;
    logic       last_byte;
  } vsc_in_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic              truncated;
  } vsc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // consume one input byte
    logic cmp_init;  // prepare list walk
    logic cmp_step;  // advance the compare walk by one step
    logic emit;      // drive result strobe
  } vsc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_cmp;  // accepted byte ended string B
    logic cmp_done;
  } vsc_sts_t;
endpackage
`default_nettype wire

[hw/rtl/vsc_ctrl.sv]
// Controller state machine of the version string compare core
`default_nettype none
module vsc_ctrl
  import vsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire vsc_sts_t sts,
  output vsc_cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_INIT = 4'b0010,
    S_WALK = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  // advance state
  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    case (state)
      S_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && sts.need_cmp) state_next = S_INIT;
      end
      S_INIT: begin
        cmd.cmp_init = 1'b1;
        state_next   = S_WALK;
      end
      S_WALK: begin
        cmd.cmp_step = 1'b1;
        if (sts.cmp_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  `include "version_string_compare_core_defines.svh"
  `VSC_ASSERT_IMP(a_busy_idle, clk, rst, state == S_LOAD, !busy)
  `VSC_ASSERT_NEXT(a_emit_once, clk, rst, cmd.emit, !cmd.emit)
  `VSC_ASSERT_NEXT(a_init_walk, clk, rst, cmd.cmp_init, cmd.cmp_step)
endmodule
`default_nettype wire

[hw/rtl/vsc_datapath.sv]
// Datapath: byte parser, text and part stores, compare walker
`default_nettype none
module vsc_datapath
  import vsc_pkg::*;
#(
  parameter int MAX_TEXT  = MaxTextDef,
  parameter int MAX_PARTS = MaxPartsDef
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire vsc_cmd_t cmd,
  input  wire vsc_in_t  din,
  input  wire logic     reverse_order,
  output vsc_sts_t      sts,
  output logic          result_valid,
  output vsc_out_t      result
);
  localparam int TW = $clog2(MAX_TEXT);
  localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int WW = $clog2(MAX_TEXT + 1);

  // Stores
  logic [7:0]  text_a [MAX_TEXT];
  logic [7:0]  text_b [MAX_TEXT];
  logic [31:0] parts_a [MAX_PARTS];
  logic [31:0] parts_b [MAX_PARTS];
  logic [MAX_PARTS-1:0] marks_a, marks_b;
  logic [CW-1:0] cnt_a, cnt_b;

  // Parser state
  logic [1:0]    mode;
  logic [31:0]   accum;
  logic          ovf;
  logic [WW-1:0] run_start, wpos;
  logic          cut, sel, pending;

  // ---------------- parse (combinational next values) ----------------
  logic [7:0] c;
  logic       fresh, digit, alpha, do_close, do_store, do_startrun;
  logic [1:0] mode_a, mode_n, newmode;
  logic [CW-1:0] cnt_cur;
  logic [WW-1:0] rs_a, wpos_a;
  logic       ovf_a;
  logic [31:0] accum_a;
  logic [35:0] mul;
  logic        close_pre;
  logic        close_any;
  logic [1:0]  close_mode;
  logic [WW-1:0] close_wpos;
  logic        cut_n;

  assign c = din.char_byte;
  assign fresh = pending || (din.string_sel != sel);
  assign digit = (c >= ChZero) && (c <= ChNine);
  assign alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  // an unfinished old string is closed before switching
  assign close_pre = fresh && !pending && (mode == ModeDigit || mode == ModeAlpha);
  assign mode_a = fresh ? ModeIdle : mode;
  assign wpos_a = fresh ? '0 : wpos;
  assign rs_a   = fresh ? '0 : run_start;
  assign ovf_a  = fresh ? 1'b0 : ovf;
  assign accum_a = fresh ? 32'd0 : accum;
  assign cnt_cur = fresh ? '0 : (din.string_sel ? cnt_b : cnt_a);
  assign do_store = (mode_a != ModeEnded) && (c != 8'd0) && (wpos_a < WW'(MAX_TEXT));

  always_comb begin
    do_close = 1'b0;
    do_startrun = 1'b0;
    newmode = ModeIdle;
    mode_n = mode_a;
    if (mode_a != ModeEnded) begin
      if (c == 8'd0) begin
        do_close = 1'b1;
        mode_n = ModeEnded;
      end else if (do_store) begin
        if (digit) begin
          if (mode_a != ModeDigit) begin
            do_close = 1'b1; do_startrun = 1'b1; newmode = ModeDigit;
          end
        end else if (alpha) begin
          if (mode_a != ModeAlpha) begin
            do_close = 1'b1; do_startrun = 1'b1; newmode = ModeAlpha;
          end
        end else if (c == ChDash) begin
          do_close = 1'b1; do_startrun = 1'b1; newmode = ModeAlpha;
        end else begin
          do_close = 1'b1;
        end
        if (do_close) mode_n = ModeIdle;
        if (do_startrun && cnt_cur < CW'(MAX_PARTS)) mode_n = newmode;
      end
    end
  end

  // a new string A clears the flag; a dropped byte sets it
  always_comb begin
    cut_n = (fresh && !din.string_sel) ? 1'b0 : cut;
    if (mode_a != ModeEnded && c != 8'd0 && !do_store) cut_n = 1'b1;
  end

  // close happens at most once per byte on the current string
  logic started;
  assign started = do_startrun && (cnt_cur < CW'(MAX_PARTS));
  assign close_any  = do_close && (mode_a == ModeDigit || mode_a == ModeAlpha);
  assign close_mode = mode_a;
  assign close_wpos = wpos_a;
  // last byte on an in-progress new run closes the run it started/extended
  logic [1:0]    lmode;
  logic [WW-1:0] lrs, lwpos;
  logic          lovf;
  logic [31:0]   laccum;
  logic [WW-1:0] rs_n, wpos_n;
  logic          ovf_n;
  logic [31:0]   accum_n;

  assign mul = {4'd0, accum_a} * 36'd10 + {28'd0, c - ChZero};
  always_comb begin
    rs_n = rs_a;
    ovf_n = ovf_a;
    accum_n = accum_a;
    if (started) begin
      rs_n = wpos_a; ovf_n = 1'b0; accum_n = 32'd0;
    end
    if (do_store && digit && mode_n == ModeDigit && !ovf_n) begin
      if (started) begin
        accum_n = {24'd0, c - ChZero};
      end else if (mul[35:32] != 4'd0) begin
        ovf_n = 1'b1;
      end else begin
        accum_n = mul[31:0];
      end
    end
    wpos_n = do_store ? wpos_a + WW'(1) : wpos_a;
  end
  // run as seen by a last-byte close (after this byte)
  assign lmode  = mode_n;
  assign lrs    = rs_n;
  assign lwpos  = wpos_n;
  assign lovf   = ovf_n;
  assign laccum = accum_n;

  // Part writes: a pre-switch close, a close in-byte, and a last-byte close.
  // At most two land on the current string in one byte; pre-close targets old.
  logic          w1_en, w2_en;
  logic [31:0]   w1_word, w2_word;
  logic          w1_num, w2_num;
  logic [CW-1:0] w1_idx, w2_idx;
  logic          last_close;
  assign last_close = din.last_byte && (lmode == ModeDigit || lmode == ModeAlpha);
  always_comb begin
    w1_en = close_any && (cnt_cur < CW'(MAX_PARTS));
    w1_num = (close_mode == ModeDigit) && !ovf_a;
    w1_word = w1_num ? accum_a :
      {16'(close_wpos - rs_a), 16'(rs_a)};
    w1_idx = cnt_cur;
    w2_idx = cnt_cur + CW'(w1_en);
    w2_num = (lmode == ModeDigit) && !lovf;
    w2_word = w2_num ? laccum : {16'(lwpos - lrs), 16'(lrs)};
    w2_en = last_close && (w2_idx < CW'(MAX_PARTS));
  end

  // pre-switch close for the old string
  logic [CW-1:0] cnt_old;
  logic          pre_num;
  logic [31:0]   pre_word;
  assign cnt_old  = sel ? cnt_b : cnt_a;
  assign pre_num  = (mode == ModeDigit) && !ovf;
  assign pre_word = pre_num ? accum : {16'(wpos - run_start), 16'(run_start)};

  // next number marks of the current and the old string
  logic [MAX_PARTS-1:0] marks_new, marks_pre;
  always_comb begin
    marks_new = fresh ? '0 : (din.string_sel ? marks_b : marks_a);
    if (w1_en) marks_new[w1_idx[PW-1:0]] = w1_num;
    if (w2_en) marks_new[w2_idx[PW-1:0]] = w2_num;
    marks_pre = sel ? marks_b : marks_a;
    marks_pre[cnt_old[PW-1:0]] = pre_num;
  end

  // ---------------- compare walker ----------------
  logic [CW-1:0] idx, common;
  logic [WW-1:0] ci;           // chunk byte index
  logic [1:0]    res;
  logic          done;
  logic [31:0]   pa_r, pb_r;
  logic          na_r, nb_r;
  logic [7:0]    ta_r, tb_r;
  logic [1:0]    phase;        // 0 fetch parts, 1 decide, 2 fetch text, 3 text cmp
  logic [WW-1:0] la, lb, oa, ob, lmin;
  assign oa = WW'(pa_r[15:0]);
  assign ob = WW'(pb_r[15:0]);
  assign la = WW'(pa_r[31:16]);
  assign lb = WW'(pb_r[31:16]);
  assign lmin = (la < lb) ? la : lb;
  logic [WW:0] xa, xb;
  assign xa = {1'b0, oa} + {1'b0, ci};
  assign xb = {1'b0, ob} + {1'b0, ci};
  assign common = (cnt_a < cnt_b) ? cnt_a : cnt_b;
  logic [PW-1:0] pidx;
  assign pidx = idx[PW-1:0];
  logic na_i, nb_i;
  assign na_i = (idx < CW'(MAX_PARTS)) ? marks_a[pidx] : 1'b0;
  assign nb_i = (idx < CW'(MAX_PARTS)) ? marks_b[pidx] : 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeIdle; accum <= '0; ovf <= 1'b0; run_start <= '0; wpos <= '0;
      cut <= 1'b0; sel <= 1'b0; pending <= 1'b1;
      marks_a <= '0; marks_b <= '0; cnt_a <= '0; cnt_b <= '0;
      done <= 1'b0; result_valid <= 1'b0; res <= OrdEq; phase <= 2'd0;
      idx <= '0; ci <= '0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.load) begin
        // close the unfinished old string
        if (close_pre && cnt_old < CW'(MAX_PARTS)) begin
          if (sel) begin
            parts_b[cnt_old[PW-1:0]] <= pre_word;
            marks_b <= marks_pre;
            cnt_b <= cnt_old + CW'(1);
          end else begin
            parts_a[cnt_old[PW-1:0]] <= pre_word;
            marks_a <= marks_pre;
            cnt_a <= cnt_old + CW'(1);
          end
        end
        if (fresh) sel <= din.string_sel;
        cut <= cut_n;
        if (do_store) begin
          if (din.string_sel) text_b[wpos_a[TW-1:0]] <= c;
          else text_a[wpos_a[TW-1:0]] <= c;
        end
        if (w1_en) begin
          if (din.string_sel) parts_b[w1_idx[PW-1:0]] <= w1_word;
          else parts_a[w1_idx[PW-1:0]] <= w1_word;
        end
        if (w2_en) begin
          if (din.string_sel) parts_b[w2_idx[PW-1:0]] <= w2_word;
          else parts_a[w2_idx[PW-1:0]] <= w2_word;
        end
        if (din.string_sel) begin
          cnt_b <= cnt_cur + CW'(w1_en) + CW'(w2_en);
          marks_b <= marks_new;
        end else begin
          cnt_a <= cnt_cur + CW'(w1_en) + CW'(w2_en);
          marks_a <= marks_new;
        end
        mode <= din.last_byte ? ModeIdle : mode_n;
        pending <= din.last_byte;
        run_start <= rs_n; wpos <= wpos_n; ovf <= ovf_n; accum <= accum_n;
      end
      if (cmd.cmp_init) begin
        idx <= '0; phase <= 2'd0; done <= 1'b0; res <= OrdEq;
      end
      if (cmd.cmp_step && !done) begin
        case (phase)
          2'd0: begin
            if (idx >= common) begin
              done <= 1'b1;
              if (cnt_a < cnt_b) res <= nb_i ? OrdLess : OrdMore;
              else if (cnt_a > cnt_b) res <= na_i ? OrdMore : OrdLess;
              else res <= OrdEq;
            end else begin
              pa_r <= parts_a[pidx]; pb_r <= parts_b[pidx];
              na_r <= na_i; nb_r <= nb_i; phase <= 2'd1;
            end
          end
          2'd1: begin
            ci <= '0;
            if (na_r != nb_r) begin
              done <= 1'b1; res <= na_r ? OrdMore : OrdLess;
            end else if (na_r) begin
              if (pa_r != pb_r) begin
                done <= 1'b1; res <= (pa_r < pb_r) ? OrdLess : OrdMore;
              end else begin
                idx <= idx + CW'(1); phase <= 2'd0;
              end
            end else begin
              phase <= 2'd2;
            end
          end
          2'd2: begin
            if (ci >= lmin) begin
              if (la != lb) begin
                done <= 1'b1; res <= (la < lb) ? OrdLess : OrdMore;
              end else begin
                idx <= idx + CW'(1); phase <= 2'd0;
              end
            end else begin
              ta_r <= (xa < (WW+1)'(MAX_TEXT)) ? text_a[xa[TW-1:0]] : 8'd0;
              tb_r <= (xb < (WW+1)'(MAX_TEXT)) ? text_b[xb[TW-1:0]] : 8'd0;
              phase <= 2'd3;
            end
          end
          default: begin
            if (ta_r != tb_r) begin
              done <= 1'b1; res <= (ta_r < tb_r) ? OrdLess : OrdMore;
            end else begin
              ci <= ci + WW'(1); phase <= 2'd2;
            end
          end
        endcase
      end
    end
  end

  assign sts.need_cmp = din.string_sel && din.last_byte;
  assign sts.cmp_done = done;
  assign result.order = reverse_order ? -res : res;
  assign result.truncated = cut;

  `include "version_string_compare_core_defines.svh"
  `VSC_ASSERT_IMP(a_cnt_a, clk, rst, 1'b1, cnt_a <= CW'(MAX_PARTS))
  `VSC_ASSERT_IMP(a_cnt_b, clk, rst, 1'b1, cnt_b <= CW'(MAX_PARTS))
  `VSC_ASSERT_IMP(a_wpos, clk, rst, 1'b1, wpos <= WW'(MAX_TEXT))
  `VSC_ASSERT_IMP(a_ord, clk, rst, result_valid, res != 2'b10)
endmodule
`default_nettype wire

[hw/rtl/version_string_compare_core.sv]
// Top level of the version string compare core
// channel   | signals                          | transfer when
// input     | start, busy, din                 | start && !busy
// result    | done, dout                       | done (one cycle, no stall)
// config    | psel penable pwrite paddr pwdata | psel && penable && pwrite
// A byte is accepted whenever start is high and busy is low. The last byte of
// string B starts a compare walk: a setup state, a fetch and a decide step per
// part, for a text part a fetch and a compare step per compared byte and a
// length check, a list tail step if reached, a step to see the decision and an
// emit state; the result shows in the next cycle, when busy is already low.
// Reset is synchronous and clears all counts and marks; results cannot stall.
`default_nettype none
module version_string_compare_core
  import vsc_pkg::*;
#(
  parameter int MAX_TEXT  = MaxTextDef,
  parameter int MAX_PARTS = MaxPartsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire vsc_in_t     din,
  output logic             done,
  output vsc_out_t         dout,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  vsc_cmd_t cmd;
  vsc_sts_t sts;
  logic     reverse_order;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) reverse_order <= 1'b0;
    else if (psel && penable && pwrite && paddr == AddrReverse) reverse_order <= pwdata[0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == AddrReverse) ? {31'd0, reverse_order} : 32'd0;

  vsc_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .cmd);

  vsc_datapath #(.MAX_TEXT(MAX_TEXT), .MAX_PARTS(MAX_PARTS)) u_dp (
    .clk, .rst, .cmd, .din, .reverse_order, .sts,
    .result_valid(done), .result(dout)
  );
endmodule
`default_nettype wire
